[rtl/v4fx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v4fx_pkg
// Shared constants, types and helpers for the Q16.16 four-component vector
// unit: action and fault codes, the transaction record and saturation.
// ----------------------------------------------------------------------------
package v4fx_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int LANES      = 4;
   localparam int NPROD      = 6;
   localparam int MUL_BITS   = WORD_WIDTH + 1;
   localparam int PROD_BITS  = 2 * MUL_BITS;
   localparam int SUM_BITS   = PROD_BITS + 2;
   localparam int SQ_BITS    = 2 * WORD_WIDTH;
   localparam int SQRT_STEPS = WORD_WIDTH;
   localparam int DIV_BITS   = WORD_WIDTH + FRAC_BITS;

   localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [WORD_WIDTH-1:0] ONE_FX =
      {{(WORD_WIDTH-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [SQ_BITS-1:0] SQ_TOP_BIT = {2'b01, {(SQ_BITS-2){1'b0}}};

   typedef enum logic [3:0] {
      ACT_ADD       = 4'd0,
      ACT_SUB       = 4'd1,
      ACT_MUL       = 4'd2,
      ACT_SCALE     = 4'd3,
      ACT_DIVIDE    = 4'd4,
      ACT_DOT       = 4'd5,
      ACT_CROSS     = 4'd6,
      ACT_LENGTH    = 4'd7,
      ACT_DISTANCE  = 4'd8,
      ACT_NORMALIZE = 4'd9,
      ACT_CLAMP     = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      FAULT_OK   = 2'd0,
      FAULT_SAT  = 2'd1,
      FAULT_DIV0 = 2'd2
   } fault_type;

   typedef struct packed {
      logic [3:0]                        act;
      logic [LANES-1:0][WORD_WIDTH-1:0]  a;
      logic [WORD_WIDTH-1:0]             s;
      logic [LANES-1:0][WORD_WIDTH-1:0]  r;
      logic [WORD_WIDTH-1:0]             rs;
      logic                              ov;
      logic [NPROD-1:0][MUL_BITS-1:0]    ma;
      logic [NPROD-1:0][MUL_BITS-1:0]    mb;
      logic [NPROD-1:0][PROD_BITS-1:0]   prod;
      logic [SQ_BITS-1:0]                sq_n;
      logic [SQ_BITS-1:0]                sq_r;
      logic [SQ_BITS-1:0]                sq_bit;
      logic                              dz;
      logic [WORD_WIDTH-1:0]             dv;
      logic [LANES-1:0]                  neg;
      logic [LANES-1:0][DIV_BITS-1:0]    num;
      logic [LANES-1:0][WORD_WIDTH-1:0]  rem;
      logic [LANES-1:0][DIV_BITS-1:0]    quo;
   } item_type;

   // {overflow, value}
   function automatic logic [WORD_WIDTH:0] sat_word(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      hi = SUM_BITS'($signed({1'b0, WORD_MAX}));
      lo = SUM_BITS'($signed(WORD_MIN));
      if (v > hi) begin
         return {1'b1, WORD_MAX};
      end else if (v < lo) begin
         return {1'b1, WORD_MIN};
      end
      return {1'b0, v[WORD_WIDTH-1:0]};
   endfunction

   function automatic logic [WORD_WIDTH-1:0] sign_sat(input logic [WORD_WIDTH-1:0] a);
      if (a == '0) begin
         return '0;
      end else if (a[WORD_WIDTH-1]) begin
         return WORD_MIN;
      end
      return WORD_MAX;
   endfunction

endpackage
`default_nettype wire

[rtl/v4fx_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v4fx_front
// Three-stage front end: operand selection and element-wise results, the
// six shared multipliers, then product rounding and the sum of squares.
// ----------------------------------------------------------------------------
module v4fx_front (
   input  wire logic                                                    clock,
   input  wire logic                                                    reset,
   input  wire logic                                                    enable,
   input  wire logic                                                    in_valid,
   input  wire logic [3:0]                                              in_act,
   input  wire logic [v4fx_pkg::LANES-1:0][v4fx_pkg::WORD_WIDTH-1:0]    in_a,
   input  wire logic [v4fx_pkg::LANES-1:0][v4fx_pkg::WORD_WIDTH-1:0]    in_b,
   input  wire logic [v4fx_pkg::WORD_WIDTH-1:0]                         in_s,
   input  wire logic [v4fx_pkg::WORD_WIDTH-1:0]                         in_bh,
   output logic                                                         out_valid,
   output v4fx_pkg::item_type                                           out_item
);
   import v4fx_pkg::*;

   item_type st1_in, st1_ff, st2_in, st2_ff, st3_in, st3_ff;
   logic [2:0] vld_in, vld_ff;

   logic signed [SUM_BITS-1:0]  add_v [LANES];
   logic signed [SUM_BITS-1:0]  sub_v [LANES];
   logic signed [MUL_BITS-1:0]  ext_a [LANES];
   logic signed [MUL_BITS-1:0]  ext_b [LANES];
   logic signed [MUL_BITS-1:0]  ext_s;
   logic signed [MUL_BITS-1:0]  abs_a [LANES];
   logic signed [MUL_BITS-1:0]  dif   [LANES];
   logic signed [MUL_BITS-1:0]  abs_d [LANES];
   logic [WORD_WIDTH-1:0]       clo   [LANES];
   logic [WORD_WIDTH:0]         sv_a;

   logic signed [PROD_BITS-1:0] shp [NPROD];
   logic signed [SUM_BITS-1:0]  dsum;
   logic signed [SUM_BITS-1:0]  cdif [3];
   logic [SQ_BITS+1:0]          sq_sum;
   logic [WORD_WIDTH:0]         sv_c;

   // stage 1: operands and element-wise results
   always_comb begin
      st1_in = '0;
      st1_in.act = in_act;
      st1_in.a = in_a;
      st1_in.s = in_s;
      sv_a = '0;
      ext_s = MUL_BITS'($signed(in_s));
      for (int i = 0; i < LANES; i++) begin
         ext_a[i] = MUL_BITS'($signed(in_a[i]));
         ext_b[i] = MUL_BITS'($signed(in_b[i]));
         add_v[i] = SUM_BITS'($signed(in_a[i])) + SUM_BITS'($signed(in_b[i]));
         sub_v[i] = SUM_BITS'($signed(in_a[i])) - SUM_BITS'($signed(in_b[i]));
         abs_a[i] = ext_a[i][MUL_BITS-1] ? -ext_a[i] : ext_a[i];
         dif[i] = ext_b[i] - ext_a[i];
         abs_d[i] = dif[i][MUL_BITS-1] ? -dif[i] : dif[i];
         clo[i] = ($signed(in_a[i]) < $signed(in_bh)) ? in_a[i] : in_bh;
         clo[i] = ($signed(clo[i]) > $signed(in_s)) ? clo[i] : in_s;
      end
      case (in_act)
         ACT_ADD: begin
            for (int i = 0; i < LANES; i++) begin
               sv_a = sat_word(add_v[i]);
               st1_in.r[i] = sv_a[WORD_WIDTH-1:0];
               st1_in.ov = st1_in.ov | sv_a[WORD_WIDTH];
            end
         end
         ACT_SUB: begin
            for (int i = 0; i < LANES; i++) begin
               sv_a = sat_word(sub_v[i]);
               st1_in.r[i] = sv_a[WORD_WIDTH-1:0];
               st1_in.ov = st1_in.ov | sv_a[WORD_WIDTH];
            end
         end
         ACT_MUL: begin
            for (int i = 0; i < LANES; i++) begin
               st1_in.ma[i] = ext_a[i];
               st1_in.mb[i] = ext_b[i];
            end
         end
         ACT_SCALE: begin
            for (int i = 0; i < LANES; i++) begin
               st1_in.ma[i] = ext_a[i];
               st1_in.mb[i] = ext_s;
            end
         end
         ACT_DOT: begin
            for (int i = 0; i < 3; i++) begin
               st1_in.ma[i] = ext_a[i];
               st1_in.mb[i] = ext_b[i];
            end
         end
         ACT_CROSS: begin
            st1_in.ma[0] = ext_a[1]; st1_in.mb[0] = ext_b[2];
            st1_in.ma[1] = ext_a[2]; st1_in.mb[1] = ext_b[1];
            st1_in.ma[2] = ext_a[2]; st1_in.mb[2] = ext_b[0];
            st1_in.ma[3] = ext_a[0]; st1_in.mb[3] = ext_b[2];
            st1_in.ma[4] = ext_a[0]; st1_in.mb[4] = ext_b[1];
            st1_in.ma[5] = ext_a[1]; st1_in.mb[5] = ext_b[0];
            st1_in.r[3] = ONE_FX;
         end
         ACT_LENGTH: begin
            for (int i = 0; i < 3; i++) begin
               st1_in.ma[i] = abs_a[i];
               st1_in.mb[i] = abs_a[i];
            end
         end
         ACT_NORMALIZE: begin
            for (int i = 0; i < 3; i++) begin
               st1_in.ma[i] = abs_a[i];
               st1_in.mb[i] = abs_a[i];
            end
            st1_in.r[3] = in_a[3];
         end
         ACT_DISTANCE: begin
            for (int i = 0; i < 3; i++) begin
               st1_in.ma[i] = abs_d[i];
               st1_in.mb[i] = abs_d[i];
            end
         end
         ACT_CLAMP: begin
            for (int i = 0; i < LANES; i++) begin
               st1_in.r[i] = clo[i];
            end
         end
         default: begin
         end
      endcase
   end

   // stage 2: the shared multipliers
   always_comb begin
      st2_in = st1_ff;
      for (int k = 0; k < NPROD; k++) begin
         st2_in.prod[k] = $signed(st1_ff.ma[k]) * $signed(st1_ff.mb[k]);
      end
   end

   // stage 3: floor rounding, saturation and squared length
   always_comb begin
      st3_in = st2_ff;
      sv_c = '0;
      for (int k = 0; k < NPROD; k++) begin
         shp[k] = $signed(st2_ff.prod[k]) >>> FRAC_BITS;
      end
      dsum = SUM_BITS'($signed(st2_ff.prod[0])) + SUM_BITS'($signed(st2_ff.prod[1]))
           + SUM_BITS'($signed(st2_ff.prod[2]));
      for (int j = 0; j < 3; j++) begin
         cdif[j] = SUM_BITS'($signed(st2_ff.prod[2*j])) - SUM_BITS'($signed(st2_ff.prod[2*j+1]));
      end
      sq_sum = {2'b00, st2_ff.prod[0][SQ_BITS-1:0]} + {2'b00, st2_ff.prod[1][SQ_BITS-1:0]}
             + {2'b00, st2_ff.prod[2][SQ_BITS-1:0]};
      st3_in.sq_r = '0;
      st3_in.sq_bit = SQ_TOP_BIT;
      case (st2_ff.act)
         ACT_MUL, ACT_SCALE: begin
            for (int i = 0; i < LANES; i++) begin
               sv_c = sat_word(SUM_BITS'(shp[i]));
               st3_in.r[i] = sv_c[WORD_WIDTH-1:0];
               st3_in.ov = st3_in.ov | sv_c[WORD_WIDTH];
            end
         end
         ACT_DOT: begin
            sv_c = sat_word(dsum >>> FRAC_BITS);
            st3_in.rs = sv_c[WORD_WIDTH-1:0];
            st3_in.ov = sv_c[WORD_WIDTH];
         end
         ACT_CROSS: begin
            for (int j = 0; j < 3; j++) begin
               sv_c = sat_word(cdif[j] >>> FRAC_BITS);
               st3_in.r[j] = sv_c[WORD_WIDTH-1:0];
               st3_in.ov = st3_in.ov | sv_c[WORD_WIDTH];
            end
         end
         ACT_LENGTH, ACT_DISTANCE, ACT_NORMALIZE: begin
            // sum beyond 64 bits holds at the maximum
            st3_in.sq_n = (sq_sum[SQ_BITS+1:SQ_BITS] != 2'b00) ? '1 : sq_sum[SQ_BITS-1:0];
         end
         default: begin
         end
      endcase
   end

   assign vld_in = {vld_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_item = st3_ff;

endmodule
`default_nettype wire

[rtl/v4fx_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v4fx_sqrt_cell
// One cell of the square root chain: settles one root bit per transaction
// and hands the partial remainder and root to the next cell.
// ----------------------------------------------------------------------------
module v4fx_sqrt_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire v4fx_pkg::item_type in_item,
   output logic                    out_valid,
   output v4fx_pkg::item_type      out_item
);
   import v4fx_pkg::*;

   item_type           item_in, item_ff;
   logic               valid_ff;
   logic [SQ_BITS:0]   trial;

   always_comb begin
      item_in = in_item;
      trial = {1'b0, in_item.sq_r} + {1'b0, in_item.sq_bit};
      if ({1'b0, in_item.sq_n} >= trial) begin
         item_in.sq_n = in_item.sq_n - trial[SQ_BITS-1:0];
         item_in.sq_r = (in_item.sq_r >> 1) + in_item.sq_bit;
      end else begin
         item_in.sq_r = in_item.sq_r >> 1;
      end
      item_in.sq_bit = in_item.sq_bit >> 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule
`default_nettype wire

[rtl/v4fx_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v4fx_div_cell
// One cell of the restoring divider chain: one quotient bit for each of the
// four lanes against the shared divisor.
// ----------------------------------------------------------------------------
module v4fx_div_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire v4fx_pkg::item_type in_item,
   output logic                    out_valid,
   output v4fx_pkg::item_type      out_item
);
   import v4fx_pkg::*;

   item_type              item_in, item_ff;
   logic                  valid_ff;
   logic [WORD_WIDTH:0]   part [LANES];

   always_comb begin
      item_in = in_item;
      for (int i = 0; i < LANES; i++) begin
         part[i] = {in_item.rem[i], in_item.num[i][DIV_BITS-1]};
         item_in.num[i] = {in_item.num[i][DIV_BITS-2:0], 1'b0};
         if (part[i] >= {1'b0, in_item.dv}) begin
            item_in.rem[i] = WORD_WIDTH'(part[i] - {1'b0, in_item.dv});
            item_in.quo[i] = {in_item.quo[i][DIV_BITS-2:0], 1'b1};
         end else begin
            item_in.rem[i] = part[i][WORD_WIDTH-1:0];
            item_in.quo[i] = {in_item.quo[i][DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule
`default_nettype wire

[rtl/vec4_fixed_point_vector_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vec4_fixed_point_vector_unit
// Q16.16 four-component vector unit: add, sub, mul, scale, divide, dot,
// cross, length, distance, normalize and clamp with saturation.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle unless the
// pipeline is stalled, and each result passes through 3 front stages with
// the six shared multipliers, a chain of 32 square root cells settling one
// root bit each, one divisor setup stage, a chain of 48 divider cells
// settling one quotient bit each, and the result register. Every
// transaction runs the whole chain whatever its action. Back pressure on
// rsp_ready stalls the whole pipeline in place.
module vec4_fixed_point_vector_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [3:0]                            req_action,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_a_x,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_a_y,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_a_z,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_a_w,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_b_x,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_b_y,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_b_z,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_b_w,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_scalar_operand,
   input  wire logic signed [v4fx_pkg::WORD_WIDTH-1:0] req_bound_high,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [v4fx_pkg::WORD_WIDTH-1:0]      rsp_r_x,
   output logic signed [v4fx_pkg::WORD_WIDTH-1:0]      rsp_r_y,
   output logic signed [v4fx_pkg::WORD_WIDTH-1:0]      rsp_r_z,
   output logic signed [v4fx_pkg::WORD_WIDTH-1:0]      rsp_r_w,
   output logic signed [v4fx_pkg::WORD_WIDTH-1:0]      rsp_r_scalar,
   output logic [1:0]                                 rsp_fault
);
   import v4fx_pkg::*;

   logic advance;

   logic                 fr_valid;
   item_type             fr_item;

   item_type             sq_item [SQRT_STEPS+1];
   logic [SQRT_STEPS:0]  sq_vld;

   item_type             prep_in, prep_ff;
   logic                 prep_vld_ff;
   logic [WORD_WIDTH-1:0] len;
   logic [WORD_WIDTH-1:0] amag [LANES];

   item_type             dv_item [DIV_BITS+1];
   logic [DIV_BITS:0]    dv_vld;

   item_type             fin;
   logic [2:0]           nlanes;
   logic                 fin_ov;
   logic [LANES-1:0][WORD_WIDTH-1:0] fin_r;

   logic                             rsp_valid_ff;
   logic [LANES-1:0][WORD_WIDTH-1:0] rsp_r_ff, rsp_r_in;
   logic [WORD_WIDTH-1:0]            rsp_rs_ff;
   logic [1:0]                       rsp_fault_ff, rsp_fault_in;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   v4fx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_act    (req_action),
      .in_a      ({req_a_w, req_a_z, req_a_y, req_a_x}),
      .in_b      ({req_b_w, req_b_z, req_b_y, req_b_x}),
      .in_s      (req_scalar_operand),
      .in_bh     (req_bound_high),
      .out_valid (fr_valid),
      .out_item  (fr_item)
   );

   assign sq_item[0] = fr_item;
   assign sq_vld[0] = fr_valid;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      v4fx_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (sq_vld[k]),
         .in_item   (sq_item[k]),
         .out_valid (sq_vld[k+1]),
         .out_item  (sq_item[k+1])
      );
   end

   // divisor setup, length results
   always_comb begin
      prep_in = sq_item[SQRT_STEPS];
      len = sq_item[SQRT_STEPS].sq_r[WORD_WIDTH-1:0];
      prep_in.rem = '0;
      prep_in.quo = '0;
      prep_in.num = '0;
      for (int i = 0; i < LANES; i++) begin
         amag[i] = sq_item[SQRT_STEPS].a[i][WORD_WIDTH-1] ?
                   -sq_item[SQRT_STEPS].a[i] : sq_item[SQRT_STEPS].a[i];
      end
      case (sq_item[SQRT_STEPS].act)
         ACT_LENGTH, ACT_DISTANCE: begin
            if (len[WORD_WIDTH-1]) begin
               prep_in.rs = WORD_MAX;
               prep_in.ov = 1'b1;
            end else begin
               prep_in.rs = len;
            end
         end
         ACT_DIVIDE: begin
            prep_in.dv = sq_item[SQRT_STEPS].s[WORD_WIDTH-1] ?
                         -sq_item[SQRT_STEPS].s : sq_item[SQRT_STEPS].s;
            prep_in.dz = (sq_item[SQRT_STEPS].s == '0);
            for (int i = 0; i < LANES; i++) begin
               prep_in.neg[i] = sq_item[SQRT_STEPS].a[i][WORD_WIDTH-1] ^
                                sq_item[SQRT_STEPS].s[WORD_WIDTH-1];
               prep_in.num[i] = {amag[i], {FRAC_BITS{1'b0}}};
            end
         end
         ACT_NORMALIZE: begin
            prep_in.dv = len;
            prep_in.dz = (len == '0);
            for (int i = 0; i < 3; i++) begin
               prep_in.neg[i] = sq_item[SQRT_STEPS].a[i][WORD_WIDTH-1];
               prep_in.num[i] = {amag[i], {FRAC_BITS{1'b0}}};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (advance) begin
         prep_vld_ff <= sq_vld[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_ff <= prep_in;
      end
   end

   assign dv_item[0] = prep_ff;
   assign dv_vld[0] = prep_vld_ff;

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      v4fx_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (dv_vld[k]),
         .in_item   (dv_item[k]),
         .out_valid (dv_vld[k+1]),
         .out_item  (dv_item[k+1])
      );
   end

   // quotient sign, saturation and fault code
   always_comb begin
      fin = dv_item[DIV_BITS];
      fin_r = fin.r;
      fin_ov = fin.ov;
      case (fin.act)
         ACT_DIVIDE:    nlanes = 3'd4;
         ACT_NORMALIZE: nlanes = 3'd3;
         default:       nlanes = 3'd0;
      endcase
      for (int i = 0; i < LANES; i++) begin
         if (i < int'(nlanes)) begin
            if (fin.dz) begin
               fin_r[i] = sign_sat(fin.a[i]);
            end else if (!fin.neg[i]) begin
               if (fin.quo[i] > {{(DIV_BITS-WORD_WIDTH){1'b0}}, WORD_MAX}) begin
                  fin_r[i] = WORD_MAX;
                  fin_ov = 1'b1;
               end else begin
                  fin_r[i] = fin.quo[i][WORD_WIDTH-1:0];
               end
            end else begin
               if (fin.quo[i] > {{(DIV_BITS-WORD_WIDTH){1'b0}}, WORD_MIN}) begin
                  fin_r[i] = WORD_MIN;
                  fin_ov = 1'b1;
               end else begin
                  fin_r[i] = -fin.quo[i][WORD_WIDTH-1:0];
               end
            end
         end
      end
      rsp_r_in = fin_r;
      if (fin.dz) begin
         rsp_fault_in = FAULT_DIV0;
      end else if (fin_ov) begin
         rsp_fault_in = FAULT_SAT;
      end else begin
         rsp_fault_in = FAULT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_vld[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_r_ff <= rsp_r_in;
         rsp_rs_ff <= fin.rs;
         rsp_fault_ff <= rsp_fault_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_r_x = rsp_r_ff[0];
   assign rsp_r_y = rsp_r_ff[1];
   assign rsp_r_z = rsp_r_ff[2];
   assign rsp_r_w = rsp_r_ff[3];
   assign rsp_r_scalar = rsp_rs_ff;
   assign rsp_fault = rsp_fault_ff;

`ifndef SYNTHESIS
   // the root of a 64-bit sum always fits one word
   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      sq_vld[SQRT_STEPS] |->
         sq_item[SQRT_STEPS].sq_r[SQ_BITS-1:WORD_WIDTH] == '0)
      else $error("square root chain produced a root wider than a word");

   // restoring division keeps every remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_vld[DIV_BITS] && dv_item[DIV_BITS].dv != '0) |->
         (dv_item[DIV_BITS].rem[0] < dv_item[DIV_BITS].dv &&
          dv_item[DIV_BITS].rem[1] < dv_item[DIV_BITS].dv &&
          dv_item[DIV_BITS].rem[2] < dv_item[DIV_BITS].dv &&
          dv_item[DIV_BITS].rem[3] < dv_item[DIV_BITS].dv))
      else $error("divider remainder not below divisor");

   // only divide and normalize can flag a zero divisor
   a_dz_source: assert property (@(posedge clock) disable iff (reset)
      (dv_vld[DIV_BITS] && dv_item[DIV_BITS].dz) |->
         (dv_item[DIV_BITS].act == ACT_DIVIDE || dv_item[DIV_BITS].act == ACT_NORMALIZE))
      else $error("zero divisor flagged on an action without a divisor");
`endif

endmodule
`default_nettype wire
